// ----- src/rkl_pkg.sv -----
// Shared types and constants for the running order-statistic block.
package rkl_pkg;

  typedef enum logic [16:0] {
    ST_IDLE    = 17'b00000000000000001,
    ST_MOD     = 17'b00000000000000010,
    ST_MVRD    = 17'b00000000000000100,
    ST_UPUSH   = 17'b00000000000001000,
    ST_SU      = 17'b00000000000010000,
    ST_SU_CMP  = 17'b00000000000100000,
    ST_LPOP    = 17'b00000000001000000,
    ST_LPOP_LD = 17'b00000000010000000,
    ST_SD      = 17'b00000000100000000,
    ST_SD_L    = 17'b00000001000000000,
    ST_SD_R    = 17'b00000010000000000,
    ST_SD_MV   = 17'b00000100000000000,
    ST_CMPRD   = 17'b00001000000000000,
    ST_CMP     = 17'b00010000000000000,
    ST_LPUSH   = 17'b00100000000000000,
    ST_TOPRD   = 17'b01000000000000000,
    ST_OUT     = 17'b10000000000000000
  } state_t;

  // Selects which heap the shared sift engine works on.
  typedef enum logic [1:0] {
    HP_LOWER = 2'b01,
    HP_UPPER = 2'b10
  } heap_sel_t;

endpackage

// ----- src/running_kth_largest_dual_heap.sv -----
// Top level of the running order-statistic block with two heaps in memory.
//
// A value arrives as one word on the s_axis channel (tdata = sample_value).
// After each word the block answers with one word on m_axis carrying the
// ceil(x/m)-th largest value seen so far, x being the count of taken values
// and m the rank_divisor register (cfg_we/cfg_wdata, reset value 1; zero
// acts as one). The lower part of the stream sits in a max-heap whose top
// is the answer; the values above it sit in a min-heap.
//
// One sift engine serves both heaps through one read port and one write
// port. An item is accepted, then the count goes through a serial
// count-modulo over its CW (11) bits, a rank move when due (a sift-up and
// a pop), a compare with the upper top, an optional replace (a sift-down)
// and a push into the lower heap, then the answer is read out. A sift-down
// reads the left and then the right child before the better one moves up;
// a word that finds the store full is not stored and goes straight to readout.
// s_axis_tready is high only while the sequencer is idle; one answer may wait
// while the next item is worked on, and a stalled receiver holds the answer.
// Reset clears the counts and sets the divisor to one; heap contents are not cleared.
module running_kth_largest_dual_heap #(
  parameter int CAPACITY    = 1024,
  parameter int VALUE_WIDTH = 20
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [10:0]            cfg_wdata,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // tdata: [VALUE_WIDTH-1:0] sample_value, zero fill above
  input  logic [((VALUE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // tdata: [VALUE_WIDTH-1:0] rank_value, [VALUE_WIDTH] store_full, zero fill
  output logic [((VALUE_WIDTH+8)/8)*8-1:0] m_axis_tdata
);
  import rkl_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int OW = ((VALUE_WIDTH + 8) / 8) * 8;
  localparam int RW = 11;
  localparam int DW = (CW > RW) ? CW : RW;
  localparam int BW = $clog2(CW);
  localparam int XW = AW + 2;

  logic [VALUE_WIDTH-1:0] lmem [CAPACITY];
  logic [VALUE_WIDTH-1:0] umem [CAPACITY];

  state_t state;
  heap_sel_t hsel;               // heap that the sift engine works on
  logic [RW-1:0] rank_divisor;
  logic [CW-1:0] lsize, usize, seen;
  logic upper_in_use;
  logic [VALUE_WIDTH-1:0] sample, moving, cur, best_val, ltop;
  logic [AW-1:0] pos, best_pos;
  logic [CW-1:0] msize;          // heap size seen by a sift-down
  logic full_flag, out_full;
  // Serial remainder: seen mod m via restoring division, one bit per cycle.
  logic [DW-1:0] rem;
  logic [BW-1:0] bitc;

  // Memory port controls, decoded from the state.
  logic [VALUE_WIDTH-1:0] rdata;
  heap_sel_t rd_sel;
  logic [AW-1:0] raddr;
  logic we;
  logic [AW-1:0] waddr;
  logic [VALUE_WIDTH-1:0] wdata;
  logic present;

  logic [DW:0] rem_sh;
  logic [DW-1:0] mdiv;
  logic [XW-1:0] lch, rch, msize_x;
  logic [AW-1:0] par;
  logic [CW-1:0] lsize_m1;

  // shared compare: true when a belongs above b in the selected heap
  function automatic logic above(heap_sel_t h, logic [VALUE_WIDTH-1:0] a,
                                 logic [VALUE_WIDTH-1:0] b);
    above = (h == HP_LOWER) ? (a > b) : (a < b);
  endfunction

  assign mdiv     = (rank_divisor == '0) ? DW'(1) : DW'(rank_divisor);
  assign rem_sh   = {rem, seen[bitc]};
  assign lch      = {1'b0, pos, 1'b1};
  assign rch      = lch + XW'(1);
  assign msize_x  = XW'(msize);
  assign par      = (pos - AW'(1)) >> 1;
  assign lsize_m1 = lsize - CW'(1);

  assign s_axis_tready = (state == ST_IDLE);
  // The answer register is loaded once the previous word has been taken.
  assign present = (state == ST_OUT) && (!m_axis_tvalid || m_axis_tready);

  // Each state issues at most one read and one write. A read issued in one
  // state returns its data in the next state.
  always_comb begin
    rd_sel = hsel;
    raddr  = '0;
    we     = 1'b0;
    waddr  = pos;
    wdata  = moving;
    unique case (state)
      ST_MVRD:  rd_sel = HP_LOWER;
      ST_LPOP: begin
        rd_sel = HP_LOWER;
        raddr  = lsize_m1[AW-1:0];
      end
      ST_CMPRD: rd_sel = HP_UPPER;
      ST_TOPRD: rd_sel = HP_LOWER;
      ST_OUT:   rd_sel = HP_LOWER;
      ST_SU: begin
        if (pos == '0) we = 1'b1;
        else raddr = par;
      end
      ST_SU_CMP: begin
        // The parent moves down into the hole, or the value settles here.
        we = 1'b1;
        if (above(hsel, moving, rdata)) wdata = rdata;
      end
      ST_SD: begin
        if (lch < msize_x) raddr = lch[AW-1:0];
        else we = 1'b1;
      end
      ST_SD_L:  raddr = rch[AW-1:0];
      ST_SD_MV: begin
        // The better child moves up into the hole, or the value settles here.
        we = 1'b1;
        if (best_pos != pos) wdata = best_val;
      end
      default: ;
    endcase
  end

  // memory: one registered read port and one write port across both heaps
  always_ff @(posedge clk) begin
    if (we && hsel == HP_LOWER) lmem[waddr] <= wdata;
    if (we && hsel == HP_UPPER) umem[waddr] <= wdata;
    rdata <= (rd_sel == HP_LOWER) ? lmem[raddr] : umem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE; hsel <= HP_LOWER; rank_divisor <= RW'(1);
      lsize <= '0; usize <= '0; seen <= '0; upper_in_use <= 1'b0;
      m_axis_tvalid <= 1'b0; ltop <= '0; out_full <= 1'b0;
    end else begin
      if (cfg_we) rank_divisor <= cfg_wdata;
      if (present) begin
        ltop <= (lsize != '0) ? rdata : '0;
        out_full <= full_flag;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: if (s_axis_tvalid) begin
          sample <= s_axis_tdata[VALUE_WIDTH-1:0];
          if (seen >= CW'(CAPACITY)) begin
            full_flag <= 1'b1; state <= ST_TOPRD;
          end else begin
            full_flag <= 1'b0; rem <= '0; bitc <= BW'(CW - 1);
            state <= ST_MOD;
          end
        end
        ST_MOD: begin
          // restoring division step on seen by m, MSB first
          if (rem_sh >= {1'b0, mdiv}) rem <= DW'(rem_sh - {1'b0, mdiv});
          else rem <= rem_sh[DW-1:0];
          if (bitc == '0) state <= ST_MVRD;
          else bitc <= bitc - BW'(1);
        end
        ST_MVRD: begin
          // The lower top read is issued here in case the rank moves.
          if (seen != '0 && rem == '0 && lsize != '0) state <= ST_UPUSH;
          else state <= ST_CMPRD;
        end
        ST_UPUSH: begin
          // rdata holds the lower top; push it into the min-heap
          moving <= rdata; hsel <= HP_UPPER; pos <= usize[AW-1:0];
          usize <= usize + CW'(1); upper_in_use <= 1'b1; state <= ST_SU;
        end
        ST_SU: begin
          if (pos != '0) state <= ST_SU_CMP;
          else if (hsel == HP_UPPER) state <= ST_LPOP;
          else state <= ST_TOPRD;
        end
        ST_SU_CMP: begin
          if (above(hsel, moving, rdata)) begin
            pos <= par; state <= ST_SU;
          end else if (hsel == HP_UPPER) state <= ST_LPOP;
          else state <= ST_TOPRD;
        end
        ST_LPOP: begin
          // pop lower: the last entry is read and sifted down from the root
          hsel <= HP_LOWER; lsize <= lsize_m1; msize <= lsize_m1;
          state <= ST_LPOP_LD;
        end
        ST_LPOP_LD: begin
          moving <= rdata; pos <= '0; state <= ST_SD;
        end
        ST_SD: begin
          if (lch < msize_x) state <= ST_SD_L;
          else if (hsel == HP_UPPER) state <= ST_LPUSH;
          else state <= ST_CMPRD;
        end
        ST_SD_L: begin
          if (above(hsel, rdata, moving)) begin
            best_val <= rdata; best_pos <= lch[AW-1:0];
          end else begin
            best_val <= moving; best_pos <= pos;
          end
          if (rch < msize_x) state <= ST_SD_R;
          else state <= ST_SD_MV;
        end
        ST_SD_R: begin
          if (above(hsel, rdata, best_val)) begin
            best_val <= rdata; best_pos <= rch[AW-1:0];
          end
          state <= ST_SD_MV;
        end
        ST_SD_MV: begin
          if (best_pos != pos) begin
            pos <= best_pos; state <= ST_SD;
          end else if (hsel == HP_UPPER) state <= ST_LPUSH;
          else state <= ST_CMPRD;
        end
        ST_CMPRD: state <= ST_CMP;  // upper top read in flight
        ST_CMP: begin
          // rdata holds the upper top; a larger sample replaces it
          if (upper_in_use && usize != '0 && sample > rdata) begin
            cur <= rdata; moving <= sample; hsel <= HP_UPPER;
            msize <= usize; pos <= '0; state <= ST_SD;
          end else begin
            cur <= sample; state <= ST_LPUSH;
          end
        end
        ST_LPUSH: begin
          moving <= cur; hsel <= HP_LOWER; pos <= lsize[AW-1:0];
          lsize <= lsize + CW'(1); state <= ST_SU;
        end
        ST_TOPRD: state <= ST_OUT;  // lower top read in flight
        ST_OUT: begin
          // wait here until the previous answer has been taken
          if (present) begin
            if (!full_flag) seen <= seen + CW'(1);
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tdata = OW'({out_full, ltop});

  property p_ready_idle;
    @(posedge clk) disable iff (rst) s_axis_tready |-> state == ST_IDLE;
  endproperty
  a_ready_idle: assert property (p_ready_idle) else $error("ready outside idle");

  a_sizes: assert property (@(posedge clk) disable iff (rst)
    ((CW+1)'(lsize) + (CW+1)'(usize)) <= ((CW+1)'(seen) + (CW+1)'(1)))
    else $error("heap sizes exceed count");

  a_seen_cap: assert property (@(posedge clk) disable iff (rst)
    seen <= CW'(CAPACITY)) else $error("count above capacity");

  a_one_word: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("answer lost under stall");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("answer changed under stall");

endmodule
